FILE: design/usr_pkg.sv
// Shared codes for the unordered set core: request types and result status.
// No dependencies; imported by the top level and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package usr_pkg;

   // Request type codes carried on req_type.
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_DUMP   = 2'd2;

   // Result status codes carried on rsp_status.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Width of the stored_count field on the result channel.
   localparam int unsigned COUNT_PORT_W = 7;

endpackage : usr_pkg

`default_nettype wire

FILE: design/unordered_set_swap_remove_core.sv
// Top level of the unordered set core: request sequencer around one entry RAM.
// Depends on usr_pkg and usr_ram.
//
// Usage: one request is taken on the req_ channel (req_valid/req_ready) and
// carries req_type and req_value. Results leave on the rsp_ channel through
// an output register; every request except the unused type code gives at
// least one result, and the final one has rsp_last_of_run set.
// Delete scans the entry RAM one entry per cycle through its single read
// port. Dump streams one entry per cycle while the receiver does not stall.
// One request is worked on at a time; a new one is accepted once the
// previous one has handed its last result to the output register, even
// while that result still waits on rsp_ready.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; dump reads are throttled so no entry is lost.
// Reset clears the entry count and all control state; the entry RAM is not
// cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module unordered_set_swap_remove_core
   import usr_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                     [1:0] req_type,
   input  wire logic signed             [31:0] req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                          [1:0] rsp_status,
   output logic signed                  [31:0] rsp_entry_value,
   output logic             [COUNT_PORT_W-1:0] rsp_stored_count,
   output logic                                rsp_last_of_run
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_MOVE,
      ST_DUMP,
      ST_RESP
   } state_type;

   // Control registers.
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              data_valid_ff, data_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [1:0]        type_ff, type_in;
   logic [31:0]       value_ff, value_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic [1:0]        status_ff, status_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic [CW-1:0]     rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM port signals.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [31:0]       wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [31:0]       rd_data;

   // Helpers.
   logic              req_fire;
   logic              out_free;
   logic [CW-1:0]     count_less_one;
   logic [AW-1:0]     last_idx;
   logic              hit;
   logic              emit;
   logic [1:0]        emit_status;
   logic [31:0]       emit_value;
   logic              emit_last;
   logic              dump_emit;
   logic              dump_issue;

   usr_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign count_less_one = count_ff - CW'(1);
   assign last_idx       = count_less_one[AW-1:0];
   assign hit            = data_valid_ff && (rd_data == value_ff);
   assign dump_emit      = data_valid_ff && out_free;
   assign dump_issue     = (!data_valid_ff || out_free) && (scan_ff < count_ff);

   // Request sequencer: decides RAM accesses, count updates and results.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      data_valid_in = data_valid_ff;
      type_in       = type_ff;
      value_in      = value_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_idx_in    = hit_idx_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = value_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ff[AW-1:0];
      emit          = 1'b0;
      emit_status   = status_ff;
      emit_value    = 32'd0;
      emit_last     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               type_in       = req_type;
               value_in      = req_value;
               scan_in       = '0;
               data_valid_in = 1'b0;
               state_in      = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (type_ff)
               REQ_INSERT: begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     count_in  = count_ff + CW'(1);
                     status_in = STATUS_OK;
                  end
                  state_in = ST_RESP;
               end
               REQ_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               REQ_DUMP: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     state_in = ST_DUMP;
                  end
               end
               default: begin
                  // The unused type code changes nothing and gives no result.
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SCAN: begin
            // Reads are issued one per cycle; each is compared in the next cycle.
            if (hit) begin
               rd_en         = 1'b1;
               rd_addr       = last_idx;
               hit_idx_in    = cmp_idx_ff;
               data_valid_in = 1'b0;
               state_in      = ST_MOVE;
            end else if (data_valid_ff && (cmp_idx_ff == last_idx)) begin
               status_in     = STATUS_NOT_FOUND;
               data_valid_in = 1'b0;
               state_in      = ST_RESP;
            end else if (scan_ff < count_ff) begin
               rd_en         = 1'b1;
               cmp_idx_in    = scan_ff[AW-1:0];
               scan_in       = scan_ff + CW'(1);
               data_valid_in = 1'b1;
            end else begin
               data_valid_in = 1'b0;
            end
         end

         ST_MOVE: begin
            // The last entry, just read, overwrites the matching slot.
            wr_en     = 1'b1;
            wr_addr   = hit_idx_ff;
            wr_data   = rd_data;
            count_in  = count_less_one;
            status_in = STATUS_OK;
            state_in  = ST_RESP;
         end

         ST_DUMP: begin
            // Stream entries; a read is issued only when its data can move on.
            if (dump_emit) begin
               emit        = 1'b1;
               emit_status = STATUS_OK;
               emit_value  = rd_data;
               emit_last   = (cmp_idx_ff == last_idx);
            end
            if (dump_issue) begin
               rd_en         = 1'b1;
               cmp_idx_in    = scan_ff[AW-1:0];
               scan_in       = scan_ff + CW'(1);
               data_valid_in = 1'b1;
            end else if (dump_emit) begin
               data_valid_in = 1'b0;
            end
            if (dump_emit && (cmp_idx_ff == last_idx)) begin
               data_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_value_in  = emit_value;
         rsp_count_in  = count_ff;
         rsp_last_in   = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         data_valid_ff <= data_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      type_ff       <= type_in;
      value_ff      <= value_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_value  = $signed(rsp_value_ff);
   assign rsp_stored_count = COUNT_PORT_W'(rsp_count_ff);
   assign rsp_last_of_run  = rsp_last_ff;

endmodule : unordered_set_swap_remove_core

`default_nettype wire

FILE: design/usr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; the read data holds while rd_en is low.
`timescale 1ns / 1ps
`default_nettype none

module usr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : usr_ram

`default_nettype wire

FILE: design/usr_checker.sv
// Port-level checks for the unordered set core, bound to its top level.
// Depends on usr_pkg and on unordered_set_swap_remove_core.
`timescale 1ns / 1ps
`default_nettype none

module usr_checker
   import usr_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic              [1:0] req_type,
   input wire logic signed      [31:0] req_value,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic              [1:0] rsp_status,
   input wire logic signed      [31:0] rsp_entry_value,
   input wire logic [COUNT_PORT_W-1:0] rsp_stored_count,
   input wire logic                    rsp_last_of_run
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_value) && $stable(rsp_stored_count)
         && $stable(rsp_last_of_run)))
   else $error("stalled request result changed");

   // Every error result is a single result that closes its request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         (rsp_last_of_run && (rsp_entry_value == 32'sd0)))
   else $error("error result not final or carries a value");

   // A waiting request holds its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_type)
         && $stable(req_value)))
   else $error("waiting request changed before acceptance");

   // A full report only comes from a full table.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |->
         (rsp_stored_count == COUNT_PORT_W'(CAPACITY)))
   else $error("full status with room left");

   // No new request is taken while a dump still streams its entries.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> !req_ready)
   else $error("request accepted in the middle of a dump");

endmodule : usr_checker

bind unordered_set_swap_remove_core usr_checker #(
   .CAPACITY (CAPACITY)
) u_usr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_type         (req_type),
   .req_value        (req_value),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_entry_value  (rsp_entry_value),
   .rsp_stored_count (rsp_stored_count),
   .rsp_last_of_run  (rsp_last_of_run)
);

`default_nettype wire
